// File: hdl/usf_pkg.sv
package usf_pkg;

   // fixed widths of the request, response and register fields
   localparam int ROW_W      = 16;
   localparam int ROW_IDX_W  = 4;
   localparam int CNT_W      = 5;
   localparam int IDX_OUT_W  = 4;

   localparam int DEFAULT_MAX_PEOPLE = 16;
   localparam logic [CNT_W-1:0] PEOPLE_RESET = 5'd16;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ELIM,
      ST_CHECK
   } usf_state_type;

   // row write and column probe, broadcast to every lane
   typedef struct packed {
      logic                 wr_en;
      logic [ROW_IDX_W-1:0] slot;
      logic [ROW_W-1:0]     row;
      logic [ROW_IDX_W-1:0] cand;
   } usf_lane_ctl_type;

   // verification request to the merge stage
   typedef struct packed {
      logic                 load;
      logic [CNT_W-1:0]     people;
      logic [IDX_OUT_W-1:0] cand;
   } usf_check_ctl_type;

   // mask of the columns in use for a people count of n
   function automatic logic [ROW_W-1:0] people_mask(input logic [CNT_W-1:0] n);
      logic [ROW_W-1:0] shifted;
      shifted = {ROW_W{1'b1}} << n;
      return ~shifted;
   endfunction

endpackage

// File: hdl/usf_if.sv
interface usf_req_if;
   import usf_pkg::*;
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] row_bits;
   modport source (output valid, output row_bits, input ready);
   modport sink   (input valid, input row_bits, output ready);
endinterface

interface usf_rsp_if;
   import usf_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 found;
   logic [IDX_OUT_W-1:0] celebrity_index;
   modport source (output valid, output found, output celebrity_index, input ready);
   modport sink   (input valid, input found, input celebrity_index, output ready);
endinterface

interface usf_csr_if;
   import usf_pkg::*;
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] people_count;
   modport source (output valid, output people_count, input ready);
   modport sink   (input valid, input people_count, output ready);
endinterface

// File: hdl/universal_sink_finder_unit.sv
// channel   dir  signals                              role
// req_ch    in   valid ready row_bits[15:0]           one matrix row per request
// rsp_ch    out  valid ready found celebrity_index    one verdict per matrix
// csr_ch    in   valid ready people_count[4:0]        people count, restarts loading
//
// rows load at one request per cycle into per-row lanes, only while in the loading phase
// after the last row: candidate elimination (skipped for a single person), then the check
// the check waits while the verdict register is still held by rsp_ch
// reset is synchronous: row counter cleared, people count 16, no verdict pending
module universal_sink_finder_unit #(
   parameter int MAX_PEOPLE = usf_pkg::DEFAULT_MAX_PEOPLE
) (
   input logic       clock,
   input logic       reset,
   usf_req_if.sink   req_ch,
   usf_rsp_if.source rsp_ch,
   usf_csr_if.sink   csr_ch
);
   import usf_pkg::*;

   // rows beyond the row width can never be used
   localparam int PEOPLE_CAP = (MAX_PEOPLE < ROW_W) ? MAX_PEOPLE : ROW_W;
   localparam int IDX_W      = $clog2(PEOPLE_CAP);

   usf_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  row_ff, row_in;
   logic [IDX_W-1:0]  elim_ff, elim_in;
   logic [IDX_W-1:0]  cand_ff, cand_in;
   logic [CNT_W-1:0]  people_count_ff;
   logic [CNT_W-1:0]  n_eff;
   logic              req_accept;
   logic              csr_accept;
   logic              last_row;
   logic              knows;
   logic              merge_free;
   logic [ROW_W-1:0]  lane_row [PEOPLE_CAP];
   logic [ROW_W-1:0]  col_bits;
   logic [ROW_W-1:0]  cand_row;
   usf_lane_ctl_type  lane_ctl;
   usf_check_ctl_type check_ctl;

   // clamp the people count to 1 .. cap
   always_comb begin
      priority if (people_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (people_count_ff > CNT_W'(PEOPLE_CAP)) begin
         n_eff = CNT_W'(PEOPLE_CAP);
      end else begin
         n_eff = people_count_ff;
      end
   end

   assign req_ch.ready = (state_ff == ST_LOAD);
   assign csr_ch.ready = 1'b1;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_accept   = csr_ch.valid && csr_ch.ready;
   assign last_row     = (CNT_W'(row_ff) + CNT_W'(1)) >= n_eff;

   // row of the current candidate, bit of the person being compared
   assign cand_row = lane_row[cand_ff];
   assign knows    = cand_row[ROW_IDX_W'(elim_ff)];

   // lane control: row writes while loading, column probe for the candidate
   always_comb begin
      lane_ctl.wr_en = req_accept;
      lane_ctl.slot  = ROW_IDX_W'(row_ff);
      lane_ctl.row   = req_ch.row_bits & people_mask(n_eff);
      lane_ctl.cand  = ROW_IDX_W'(cand_ff);
   end

   // sequencer: load rows, eliminate candidates, hand the survivor to the merge
   always_comb begin
      state_in         = state_ff;
      row_in           = row_ff;
      elim_in          = elim_ff;
      cand_in          = cand_ff;
      check_ctl.load   = 1'b0;
      check_ctl.people = n_eff;
      check_ctl.cand   = IDX_OUT_W'(cand_ff);
      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (last_row) begin
                  row_in   = '0;
                  cand_in  = '0;
                  elim_in  = IDX_W'(1);
                  // a single person needs no elimination
                  state_in = (n_eff == CNT_W'(1)) ? ST_CHECK : ST_ELIM;
               end else begin
                  row_in = row_ff + IDX_W'(1);
               end
            end
         end
         ST_ELIM: begin
            // candidate knows this person: candidate dropped
            if (knows) begin
               cand_in = elim_ff;
            end
            if ((CNT_W'(elim_ff) + CNT_W'(1)) >= n_eff) begin
               state_in = ST_CHECK;
            end else begin
               elim_in = elim_ff + IDX_W'(1);
            end
         end
         ST_CHECK: begin
            if (merge_free) begin
               check_ctl.load = 1'b1;
               state_in       = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      // a count write restarts loading at the first row
      if (csr_accept) begin
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         row_ff          <= '0;
         people_count_ff <= PEOPLE_RESET;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         if (csr_accept) begin
            people_count_ff <= csr_ch.people_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      elim_ff <= elim_in;
      cand_ff <= cand_in;
   end

   // one lane per stored row
   genvar gi;
   generate
      for (gi = 0; gi < ROW_W; gi++) begin : g_lane
         if (gi < PEOPLE_CAP) begin : g_used
            usf_lane #(
               .LANE (gi)
            ) u_lane (
               .clock   (clock),
               .ctl     (lane_ctl),
               .row     (lane_row[gi]),
               .col_bit (col_bits[gi])
            );
         end else begin : g_unused
            assign col_bits[gi] = 1'b0;
         end
      end
   endgenerate

   // merge: column count, row check and verdict register
   usf_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .ctl      (check_ctl),
      .col_bits (col_bits),
      .cand_row (cand_row),
      .free     (merge_free),
      .rsp_ch   (rsp_ch)
   );

   // no request taken outside the loading phase
   a_ready_only_loading: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> !req_ch.ready)
      else $error("request ready outside loading");

   // a completed matrix leaves the loading phase
   a_last_row_leaves_load: assert property (@(posedge clock) disable iff (reset)
      (req_accept && last_row && !csr_accept) |=> (state_ff == ST_ELIM || state_ff == ST_CHECK))
      else $error("last row did not start elimination");

   // the candidate always comes from people already compared
   a_cand_behind_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ELIM) |-> (cand_ff < elim_ff))
      else $error("candidate ahead of elimination scan");

   // a verdict is loaded only into a free response register
   a_no_verdict_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !check_ctl.load)
      else $error("verdict overwritten while held");

   // no celebrity means index zero
   a_index_zero_when_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.found) |-> (rsp_ch.celebrity_index == '0))
      else $error("nonzero index without celebrity");

endmodule

// File: hdl/usf_lane.sv
module usf_lane #(
   parameter int LANE = 0
) (
   input  logic                      clock,
   input  usf_pkg::usf_lane_ctl_type ctl,
   output logic [usf_pkg::ROW_W-1:0] row,
   output logic                      col_bit
);
   import usf_pkg::*;

   logic [ROW_W-1:0] row_ff;

   // one matrix row per lane
   always_ff @(posedge clock) begin
      if (ctl.wr_en && (ctl.slot == ROW_IDX_W'(LANE))) begin
         row_ff <= ctl.row;
      end
   end

   assign row     = row_ff;
   assign col_bit = row_ff[ctl.cand];

endmodule

// File: hdl/usf_merge.sv
module usf_merge (
   input  logic                       clock,
   input  logic                       reset,
   input  usf_pkg::usf_check_ctl_type ctl,
   input  logic [usf_pkg::ROW_W-1:0]  col_bits,
   input  logic [usf_pkg::ROW_W-1:0]  cand_row,
   output logic                       free,
   usf_rsp_if.source                  rsp_ch
);
   import usf_pkg::*;

   logic                 valid_ff, valid_in;
   logic                 found_ff;
   logic [IDX_OUT_W-1:0] idx_ff;
   logic [ROW_W-1:0]     col_used;
   logic [CNT_W-1:0]     ones;
   logic                 ok;

   // count column hits over the rows in use
   always_comb begin
      col_used = col_bits & people_mask(ctl.people);
      ones     = CNT_W'($countones(col_used));
      ok       = (cand_row == '0) && (ones == (ctl.people - CNT_W'(1)));
   end

   assign free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         found_ff <= ok;
         idx_ff   <= ok ? ctl.cand : '0;
      end
   end

   assign rsp_ch.valid           = valid_ff;
   assign rsp_ch.found           = found_ff;
   assign rsp_ch.celebrity_index = idx_ff;

endmodule
